@@ rtl/sppi_pkg.sv @@
`timescale 1ns / 1ps

package sppi_pkg;

  // Configuration port geometry.
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  // Serial divider geometry.
  localparam int DIV_W     = 40;
  localparam int DIVISOR_W = 16;
  localparam int CNT_W     = 6;

  // Planner limits.
  localparam logic [15:0] LONG_THRESH_MAX  = 16'd768;
  localparam logic [15:0] LONG_THRESH_MIN  = 16'd77;
  localparam logic [15:0] FORCE_LONG_ERROR = 16'd512;
  localparam logic [26:0] MIN_PRESS_MS     = 27'd150;

  localparam logic [16:0] FLOOR_MARGIN = 17'd13;
  localparam logic [15:0] LEAK_NUM     = 16'd85;
  localparam logic [15:0] LEAK_DEN     = 16'd100;
  // |x| * 100 < 65536 holds exactly for |x| <= 655.
  localparam logic [31:0] SNAP_MAX     = 32'd655;
  localparam logic [15:0] INC_DEN      = 16'd1000;
  localparam logic [DIV_W-1:0] INC_ROUND = 40'd500;
  localparam logic [15:0] PRESS_SCALE  = 16'd1000;
  localparam logic [16:0] COOLDOWN_MAX = 17'd3000;

  // Significant dividend bits of each division; the dividend is left aligned.
  localparam int LEAK_BITS  = 38;
  localparam int INC_BITS   = 40;
  localparam int PRESS_BITS = 26;
  localparam int PULSE_BITS = 15;
  localparam logic [PULSE_BITS-1:0] PULSE_EFFECT = 15'd25600;

  typedef enum logic [2:0] {
    REG_INTEGRAL_CLAMP  = 3'd0,
    REG_LONG_THRESHOLD  = 3'd1,
    REG_LONG_MAX_MS     = 3'd2,
    REG_COOLDOWN_MIN_MS = 3'd3,
    REG_UP_PIN          = 3'd4,
    REG_DOWN_PIN        = 3'd5,
    REG_SPEED_MAX       = 3'd6,
    REG_SPEED_MIN       = 3'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ACT_LEAK  = 3'd0,
    ACT_HOLD  = 3'd1,
    ACT_UNSET = 3'd2,
    ACT_LONG  = 3'd3,
    ACT_PULSE = 3'd4
  } action_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_DIV1_GO,
    S_DIV1_WAIT,
    S_CLAMP,
    S_DECIDE,
    S_MUL2,
    S_DIV2_GO,
    S_DIV2_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [30:0] integral_clamp;
    logic [15:0] long_press_threshold;
    logic [15:0] long_press_max_ms;
    logic [11:0] pulse_cooldown_min_ms;
    logic [5:0]  up_pin;
    logic [5:0]  down_pin;
    logic [15:0] speed_max;
    logic [15:0] speed_min;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [CNT_W-1:0]     count;
    logic [DIV_W-1:0]     dividend;
    logic [DIVISOR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic               in_error_band;
    logic signed [15:0] speed_error;
    logic [15:0]        step_ms;
    logic [15:0]        measured_speed;
    logic [15:0]        error_magnitude;
    logic [31:0]        time_now;
    logic [15:0]        band_enter;
    logic [15:0]        rate_up;
    logic [15:0]        rate_down;
    logic [15:0]        inertia_up;
    logic [15:0]        inertia_down;
    logic [15:0]        response_delay_ms;
  } in_t;

  typedef struct packed {
    logic [2:0]         action;
    logic               direction_up;
    logic [5:0]         press_line;
    logic [15:0]        press_ms;
    logic [11:0]        cooldown_ms;
    logic signed [31:0] integral_value;
  } out_t;

endpackage

@@ rtl/sppi_div.sv @@
`timescale 1ns / 1ps

module sppi_div
  import sppi_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done,
  output logic [DIV_W-1:0] quotient
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [DIVISOR_W-1:0] rem_r, rem_nxt;
  logic [DIVISOR_W-1:0] dvs_r, dvs_nxt;
  logic [DIV_W-1:0]     q_r, q_nxt;
  logic [DIVISOR_W+1:0] trial;

  // One quotient bit per cycle: the dividend shifts out at the top while the
  // quotient bits shift in at the bottom of the same register.
  assign trial = {1'b0, rem_r, q_r[DIV_W-1]} - {2'b00, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    q_nxt    = q_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.count;
      rem_nxt  = '0;
      dvs_nxt  = req.divisor;
      q_nxt    = req.dividend;
    end else if (busy_r) begin
      if (trial[DIVISOR_W+1]) begin
        rem_nxt = {rem_r[DIVISOR_W-2:0], q_r[DIV_W-1]};
      end else begin
        rem_nxt = trial[DIVISOR_W-1:0];
      end
      q_nxt   = {q_r[DIV_W-2:0], ~trial[DIVISOR_W+1]};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    q_r   <= q_nxt;
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

@@ rtl/sppi_regs.sv @@
`timescale 1ns / 1ps

module sppi_regs
  import sppi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready,
  output cfg_t                  cfg
);

  cfg_t     cfg_r, cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx   = reg_idx_t'(cfg_paddr[CFG_ADDR_W-1:2]);
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        REG_INTEGRAL_CLAMP:  cfg_nxt.integral_clamp        = cfg_pwdata[30:0];
        REG_LONG_THRESHOLD:  cfg_nxt.long_press_threshold  = cfg_pwdata[15:0];
        REG_LONG_MAX_MS:     cfg_nxt.long_press_max_ms     = cfg_pwdata[15:0];
        REG_COOLDOWN_MIN_MS: cfg_nxt.pulse_cooldown_min_ms = cfg_pwdata[11:0];
        REG_UP_PIN:          cfg_nxt.up_pin                = cfg_pwdata[5:0];
        REG_DOWN_PIN:        cfg_nxt.down_pin              = cfg_pwdata[5:0];
        REG_SPEED_MAX:       cfg_nxt.speed_max             = cfg_pwdata[15:0];
        REG_SPEED_MIN:       cfg_nxt.speed_min             = cfg_pwdata[15:0];
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_INTEGRAL_CLAMP:  cfg_prdata = {1'b0, cfg_r.integral_clamp};
      REG_LONG_THRESHOLD:  cfg_prdata = {16'd0, cfg_r.long_press_threshold};
      REG_LONG_MAX_MS:     cfg_prdata = {16'd0, cfg_r.long_press_max_ms};
      REG_COOLDOWN_MIN_MS: cfg_prdata = {20'd0, cfg_r.pulse_cooldown_min_ms};
      REG_UP_PIN:          cfg_prdata = {26'd0, cfg_r.up_pin};
      REG_DOWN_PIN:        cfg_prdata = {26'd0, cfg_r.down_pin};
      REG_SPEED_MAX:       cfg_prdata = {16'd0, cfg_r.speed_max};
      REG_SPEED_MIN:       cfg_prdata = {16'd0, cfg_r.speed_min};
      default:             cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.integral_clamp        <= 31'd65536;
      cfg_r.long_press_threshold  <= 16'd256;
      cfg_r.long_press_max_ms     <= 16'd5000;
      cfg_r.pulse_cooldown_min_ms <= 12'd300;
      cfg_r.up_pin                <= 6'd0;
      cfg_r.down_pin              <= 6'd0;
      cfg_r.speed_max             <= 16'd5120;
      cfg_r.speed_min             <= 16'd256;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg_pready = 1'b1;
  assign cfg        = cfg_r;

endmodule

@@ rtl/speed_press_idle_planner.sv @@
`timescale 1ns / 1ps

// Plans one speed-control press per request. A request in the dead band
// leaks the stored integral by 0.85; any other request accumulates the
// rounded error-times-step into the integral and then plans a hold, an
// unset-line report, a long press or a pulse. One shared bit-serial divider
// yields one quotient bit per cycle over 38 dividend bits for the leak, 40
// for the integral increment, then 26 for a long press duration or 15 for a
// pulse cooldown. One request is in work at a time; a new one is taken while
// the previous result still waits at the output register.
module speed_press_idle_planner
  import sppi_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_t                   in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_t                  out_data,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  cfg_t             cfg;
  div_req_t         div_req;
  logic             div_done;
  logic [DIV_W-1:0] div_q;

  state_t state_r, state_nxt;
  in_t    in_r, in_nxt;
  logic signed [31:0] integ_r, integ_nxt;
  logic signed [33:0] sum_r, sum_nxt;
  logic [DIV_W-1:0]   prod_r, prod_nxt;
  logic               up_r, up_nxt;
  logic               long_r, long_nxt;
  logic [15:0]        delta_r, delta_nxt;
  logic [15:0]        rate_r, rate_nxt;
  action_t            act_r, act_nxt;
  logic [5:0]         line_r, line_nxt;
  logic [15:0]        pms_r, pms_nxt;
  logic [11:0]        cms_r, cms_nxt;
  out_t               out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Item decode.
  logic        err_neg, err_pos;
  logic [15:0] emagn;
  logic [31:0] int_mag;
  logic [31:0] mul_a;
  logic [15:0] mul_b;
  logic [47:0] mul_p;
  logic        slot_free;

  // Decision terms.
  logic        limit_hit;
  logic [5:0]  sel_line;
  logic [15:0] thr_a, thr_b;
  logic [16:0] flr_a, flr_b, thr;
  logic        want_long;
  logic [15:0] inert, rate_sel;
  logic signed [33:0] inc_s, lim_s;
  logic signed [33:0] clamped;
  logic [26:0] press_raw;
  logic [16:0] cool_raw;

  sppi_regs u_regs (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  sppi_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_q)
  );

  assign err_neg   = in_r.speed_error[15];
  assign err_pos   = !in_r.speed_error[15] && (in_r.speed_error != 16'sd0);
  assign emagn     = err_neg ? (~in_r.speed_error + 16'd1) : in_r.speed_error;
  assign int_mag   = integ_r[31] ? (~integ_r + 32'd1) : integ_r;
  assign slot_free = !out_valid_r || out_ready;

  // One shared multiplier, always followed by the product register.
  always_comb begin
    if (state_r == S_MUL1) begin
      if (in_r.in_error_band) begin
        mul_a = int_mag;
        mul_b = LEAK_NUM;
      end else begin
        mul_a = {16'd0, emagn};
        mul_b = in_r.step_ms;
      end
    end else begin
      mul_a = {16'd0, delta_r};
      mul_b = PRESS_SCALE;
    end
  end
  assign mul_p = mul_a * mul_b;

  // Integral update terms.
  assign inc_s = err_neg ? -$signed({3'b000, div_q[30:0]}) : $signed({3'b000, div_q[30:0]});
  assign lim_s = $signed({3'b000, cfg.integral_clamp});
  always_comb begin
    if (sum_r > lim_s) begin
      clamped = lim_s;
    end else if (sum_r < -lim_s) begin
      clamped = -lim_s;
    end else begin
      clamped = sum_r;
    end
  end

  // Press decision terms.
  always_comb begin
    if (up_r) begin
      limit_hit = in_r.measured_speed >= cfg.speed_max;
      sel_line  = cfg.up_pin;
      inert     = in_r.inertia_up;
      rate_sel  = in_r.rate_up;
    end else begin
      limit_hit = in_r.measured_speed <= cfg.speed_min;
      sel_line  = cfg.down_pin;
      inert     = in_r.inertia_down;
      rate_sel  = in_r.rate_down;
    end
    thr_a = (cfg.long_press_threshold > LONG_THRESH_MAX) ? LONG_THRESH_MAX
                                                         : cfg.long_press_threshold;
    thr_b = (thr_a < LONG_THRESH_MIN) ? LONG_THRESH_MIN : thr_a;
    flr_a = {1'b0, in_r.band_enter} + FLOOR_MARGIN;
    flr_b = (flr_a < {1'b0, LONG_THRESH_MIN}) ? {1'b0, LONG_THRESH_MIN} : flr_a;
    thr   = ({1'b0, thr_b} < flr_b) ? flr_b : {1'b0, thr_b};
    want_long = (in_r.error_magnitude >= FORCE_LONG_ERROR) ||
                ({1'b0, in_r.error_magnitude} >= thr);
  end

  assign press_raw = {11'd0, in_r.response_delay_ms} + {1'b0, div_q[PRESS_BITS-1:0]};
  assign cool_raw  = {1'b0, in_r.response_delay_ms} + {2'b00, div_q[PULSE_BITS-1:0]};

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:      if (in_valid) state_nxt = S_MUL1;
      S_MUL1:      state_nxt = S_DIV1_GO;
      S_DIV1_GO:   state_nxt = S_DIV1_WAIT;
      S_DIV1_WAIT: begin
        if (div_done) state_nxt = in_r.in_error_band ? S_OUT : S_CLAMP;
      end
      S_CLAMP:     state_nxt = S_DECIDE;
      S_DECIDE: begin
        if (limit_hit || (sel_line == 6'd0)) begin
          state_nxt = S_OUT;
        end else if (want_long) begin
          state_nxt = S_MUL2;
        end else begin
          state_nxt = S_DIV2_GO;
        end
      end
      S_MUL2:      state_nxt = S_DIV2_GO;
      S_DIV2_GO:   state_nxt = S_DIV2_WAIT;
      S_DIV2_WAIT: if (div_done) state_nxt = S_OUT;
      S_OUT:       if (slot_free) state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  // Datapath and outputs.
  always_comb begin
    in_nxt        = in_r;
    integ_nxt     = integ_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    up_nxt        = up_r;
    long_nxt      = long_r;
    delta_nxt     = delta_r;
    rate_nxt      = rate_r;
    act_nxt       = act_r;
    line_nxt      = line_r;
    pms_nxt       = pms_r;
    cms_nxt       = cms_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;
    div_req       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) in_nxt = in_data;
      end
      S_MUL1: prod_nxt = mul_p[DIV_W-1:0];
      S_DIV1_GO: begin
        div_req.start = 1'b1;
        if (in_r.in_error_band) begin
          div_req.count    = CNT_W'(LEAK_BITS);
          div_req.divisor  = LEAK_DEN;
          div_req.dividend = {prod_r[LEAK_BITS-1:0], {(DIV_W-LEAK_BITS){1'b0}}};
        end else begin
          div_req.count    = CNT_W'(INC_BITS);
          div_req.divisor  = INC_DEN;
          div_req.dividend = {prod_r[31:0], 8'd0} + INC_ROUND;
        end
      end
      S_DIV1_WAIT: begin
        if (div_done) begin
          if (in_r.in_error_band) begin
            // Leak truncates toward zero, then small values snap to zero.
            if (div_q[31:0] <= SNAP_MAX) begin
              integ_nxt = '0;
            end else if (integ_r[31]) begin
              integ_nxt = -$signed(div_q[31:0]);
            end else begin
              integ_nxt = $signed(div_q[31:0]);
            end
            act_nxt  = ACT_LEAK;
            up_nxt   = 1'b0;
            line_nxt = '0;
            pms_nxt  = '0;
            cms_nxt  = '0;
          end else begin
            sum_nxt = $signed({{2{integ_r[31]}}, integ_r}) + inc_s;
          end
        end
      end
      S_CLAMP: begin
        if ((err_pos && clamped < 34'sd0) || (err_neg && clamped > 34'sd0)) begin
          integ_nxt = '0;
        end else begin
          integ_nxt = clamped[31:0];
        end
        up_nxt = err_pos;
      end
      S_DECIDE: begin
        pms_nxt   = '0;
        cms_nxt   = '0;
        long_nxt  = want_long;
        delta_nxt = (in_r.error_magnitude > inert) ? (in_r.error_magnitude - inert) : 16'd0;
        rate_nxt  = (rate_sel == 16'd0) ? 16'd1 : rate_sel;
        if (limit_hit) begin
          act_nxt  = ACT_HOLD;
          line_nxt = '0;
        end else if (sel_line == 6'd0) begin
          act_nxt  = ACT_UNSET;
          line_nxt = '0;
        end else begin
          act_nxt  = want_long ? ACT_LONG : ACT_PULSE;
          line_nxt = sel_line;
        end
      end
      S_MUL2: prod_nxt = mul_p[DIV_W-1:0];
      S_DIV2_GO: begin
        div_req.start   = 1'b1;
        div_req.divisor = rate_r;
        if (long_r) begin
          div_req.count    = CNT_W'(PRESS_BITS);
          div_req.dividend = {prod_r[PRESS_BITS-1:0], {(DIV_W-PRESS_BITS){1'b0}}};
        end else begin
          div_req.count    = CNT_W'(PULSE_BITS);
          div_req.dividend = {PULSE_EFFECT, {(DIV_W-PULSE_BITS){1'b0}}};
        end
      end
      S_DIV2_WAIT: begin
        if (div_done) begin
          if (long_r) begin
            // The configured maximum wins over the minimum press.
            if (press_raw > {11'd0, cfg.long_press_max_ms}) begin
              pms_nxt = cfg.long_press_max_ms;
            end else if (press_raw < MIN_PRESS_MS) begin
              pms_nxt = (MIN_PRESS_MS > {11'd0, cfg.long_press_max_ms})
                        ? cfg.long_press_max_ms : MIN_PRESS_MS[15:0];
            end else begin
              pms_nxt = press_raw[15:0];
            end
          end else begin
            // The fixed ceiling wins over the configured minimum.
            if (cool_raw < {5'd0, cfg.pulse_cooldown_min_ms}) begin
              cms_nxt = ({5'd0, cfg.pulse_cooldown_min_ms} > COOLDOWN_MAX)
                        ? COOLDOWN_MAX[11:0] : cfg.pulse_cooldown_min_ms;
            end else if (cool_raw > COOLDOWN_MAX) begin
              cms_nxt = COOLDOWN_MAX[11:0];
            end else begin
              cms_nxt = cool_raw[11:0];
            end
          end
        end
      end
      S_OUT: begin
        if (slot_free) begin
          out_valid_nxt          = 1'b1;
          out_nxt.action         = act_r;
          out_nxt.direction_up   = up_r;
          out_nxt.press_line     = line_r;
          out_nxt.press_ms       = pms_r;
          out_nxt.cooldown_ms    = cms_r;
          out_nxt.integral_value = integ_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      integ_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      integ_r     <= integ_nxt;
      out_valid_r <= out_valid_nxt;
    end
    in_r    <= in_nxt;
    sum_r   <= sum_nxt;
    prod_r  <= prod_nxt;
    up_r    <= up_nxt;
    long_r  <= long_nxt;
    delta_r <= delta_nxt;
    rate_r  <= rate_nxt;
    act_r   <= act_nxt;
    line_r  <= line_nxt;
    pms_r   <= pms_nxt;
    cms_r   <= cms_nxt;
    out_r   <= out_nxt;
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

@@ dv/tb_speed_press_idle_planner.sv @@
`timescale 1ns / 1ps

module tb_speed_press_idle_planner
  import sppi_pkg::*;
();

  localparam int THR_CEIL       = 768;
  localparam int THR_FLOOR      = 77;
  localparam int FORCED_LONG    = 512;
  localparam int PRESS_FLOOR_MS = 150;
  localparam int BAND_MARGIN    = 13;
  localparam int COOL_CEIL_MS   = 3000;
  localparam int NUDGE_Q8       = 25600;

  localparam int PHASES          = 7;
  localparam int ITEMS_PER_PHASE = 250;
  localparam int SETTLE_CYCLES   = 10;
  localparam int QUIET_LIMIT     = 4000;

  typedef enum logic [1:0] {
    PACE_STEADY,
    PACE_SEND_GAPS,
    PACE_RECV_STALLS,
    PACE_BOTH
  } pace_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic                  cfg_psel = 1'b0;
  logic                  cfg_penable = 1'b0;
  logic                  cfg_pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [CFG_DATA_W-1:0] cfg_pwdata = '0;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  // Requests waiting for the driver, and planned results waiting for the DUT.
  in_t  tick_q[$];
  out_t plan_q[$];

  // Shadow of the configuration and of the planner state.
  cfg_t              cfg_sh;
  logic signed [31:0] integ_q = '0;
  logic               going_up_q = 1'b0;
  logic [5:0]         line_q = '0;

  int send_pct = 0;
  int recv_pct = 0;
  int n_err = 0;
  int quiet = 0;

  cfg_t  cfg_plan [PHASES];
  pace_t pace_plan [PHASES];

  speed_press_idle_planner i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string msg);
    if (n_err < 40) $display("MISMATCH at %0t: %s", $realtime, msg);
    n_err++;
  endtask

  // Computes the plan for one tick and advances the shadow state.
  function automatic out_t plan_tick(in_t t);
    out_t   r;
    longint acc, lim, inc, mag;
    int     err, spd, emag, thr, flr, rate, inert, delta, press, cool;
    logic   up;
    r    = '0;
    acc  = longint'(integ_q);
    lim  = longint'(cfg_sh.integral_clamp);
    err  = int'(t.speed_error);
    spd  = int'(t.measured_speed);
    emag = int'(t.error_magnitude);
    if (t.in_error_band) begin
      acc = (acc * 85) / 100;
      mag = (acc < 0) ? -acc : acc;
      if (mag * 100 < 65536) acc = 0;
      integ_q = acc[31:0];
      r.action = ACT_LEAK;
      r.integral_value = integ_q;
      return r;
    end
    mag = (err < 0) ? -longint'(err) : longint'(err);
    inc = (mag * longint'(t.step_ms) * 256 + 500) / 1000;
    acc = (err < 0) ? acc - inc : acc + inc;
    if (acc > lim) acc = lim;
    if (acc < -lim) acc = -lim;
    if ((err > 0 && acc < 0) || (err < 0 && acc > 0)) acc = 0;
    integ_q = acc[31:0];
    r.integral_value = integ_q;

    up = (err > 0);
    r.direction_up = up;
    if ((up && spd >= int'(cfg_sh.speed_max)) || (!up && spd <= int'(cfg_sh.speed_min))) begin
      r.action = ACT_HOLD;
      return r;
    end
    going_up_q = up;
    line_q = up ? cfg_sh.up_pin : cfg_sh.down_pin;
    if (line_q == 6'd0) begin
      r.action = ACT_UNSET;
      return r;
    end
    r.press_line = line_q;

    thr = int'(cfg_sh.long_press_threshold);
    if (thr > THR_CEIL) thr = THR_CEIL;
    if (thr < THR_FLOOR) thr = THR_FLOOR;
    flr = int'(t.band_enter) + BAND_MARGIN;
    if (flr < THR_FLOOR) flr = THR_FLOOR;
    if (thr < flr) thr = flr;
    rate = up ? int'(t.rate_up) : int'(t.rate_down);
    if (rate == 0) rate = 1;

    if (emag >= FORCED_LONG || emag >= thr) begin
      inert = up ? int'(t.inertia_up) : int'(t.inertia_down);
      delta = (emag > inert) ? emag - inert : 0;
      press = int'(t.response_delay_ms) + delta * 1000 / rate;
      if (press < PRESS_FLOOR_MS) press = PRESS_FLOOR_MS;
      if (press > int'(cfg_sh.long_press_max_ms)) press = int'(cfg_sh.long_press_max_ms);
      r.action = ACT_LONG;
      r.press_ms = press[15:0];
    end else begin
      cool = int'(t.response_delay_ms) + NUDGE_Q8 / rate;
      if (cool < int'(cfg_sh.pulse_cooldown_min_ms)) cool = int'(cfg_sh.pulse_cooldown_min_ms);
      if (cool > COOL_CEIL_MS) cool = COOL_CEIL_MS;
      r.action = ACT_PULSE;
      r.cooldown_ms = cool[11:0];
    end
    return r;
  endfunction

  // Driver: presents queued requests and records the plan of each accepted one.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) plan_q.push_back(plan_tick(in_data));
      if (!in_valid || in_ready) begin
        if (tick_q.size() != 0 && $urandom_range(99) >= send_pct) begin
          in_data  <= tick_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: stalls the result channel and checks every accepted result.
  always @(posedge clk) begin
    out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_pct);
      if (out_valid && out_ready) begin
        if (plan_q.size() == 0) begin
          report_mismatch($sformatf("result with nothing expected, action %0d integral %0d",
                                    out_data.action, out_data.integral_value));
        end else begin
          want = plan_q.pop_front();
          if (out_data.action !== want.action)
            report_mismatch($sformatf("action %0d, expected %0d",
                                      out_data.action, want.action));
          if (out_data.direction_up !== want.direction_up)
            report_mismatch($sformatf("direction_up %0d, expected %0d",
                                      out_data.direction_up, want.direction_up));
          if (out_data.press_line !== want.press_line)
            report_mismatch($sformatf("press_line %0d, expected %0d",
                                      out_data.press_line, want.press_line));
          if (out_data.press_ms !== want.press_ms)
            report_mismatch($sformatf("press_ms %0d, expected %0d",
                                      out_data.press_ms, want.press_ms));
          if (out_data.cooldown_ms !== want.cooldown_ms)
            report_mismatch($sformatf("cooldown_ms %0d, expected %0d",
                                      out_data.cooldown_ms, want.cooldown_ms));
          if (out_data.integral_value !== want.integral_value)
            report_mismatch($sformatf("integral_value %0d, expected %0d",
                                      out_data.integral_value, want.integral_value));
        end
      end
    end
  end

  // Watchdog on cycles without any handshake.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  task automatic program_regs(cfg_t c);
    write_reg(REG_INTEGRAL_CLAMP, 32'(c.integral_clamp));
    write_reg(REG_LONG_THRESHOLD, 32'(c.long_press_threshold));
    write_reg(REG_LONG_MAX_MS, 32'(c.long_press_max_ms));
    write_reg(REG_COOLDOWN_MIN_MS, 32'(c.pulse_cooldown_min_ms));
    write_reg(REG_UP_PIN, 32'(c.up_pin));
    write_reg(REG_DOWN_PIN, 32'(c.down_pin));
    write_reg(REG_SPEED_MAX, 32'(c.speed_max));
    write_reg(REG_SPEED_MIN, 32'(c.speed_min));
    cfg_sh = c;
  endtask

  task automatic set_pace(pace_t m);
    case (m)
      PACE_STEADY: begin
        send_pct = 0;
        recv_pct = 0;
      end
      PACE_SEND_GAPS: begin
        send_pct = 71;
        recv_pct = 0;
      end
      PACE_RECV_STALLS: begin
        send_pct = 0;
        recv_pct = 71;
      end
      default: begin
        send_pct = 12;
        recv_pct = 12;
      end
    endcase
  endtask

  // Sampled at the falling edge so that the driver's updates have settled.
  task automatic wait_drained();
    do @(negedge clk); while (tick_q.size() != 0 || in_valid || plan_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic in_t base_tick(bit band, int err, int step, int speed, int emag);
    in_t t;
    t.in_error_band     = band;
    t.speed_error       = err[15:0];
    t.step_ms           = step[15:0];
    t.measured_speed    = speed[15:0];
    t.error_magnitude   = emag[15:0];
    t.time_now          = $urandom;
    t.band_enter        = 16'd26;
    t.rate_up           = 16'd128;
    t.rate_down         = 16'd256;
    t.inertia_up        = 16'd13;
    t.inertia_down      = 16'd26;
    t.response_delay_ms = 16'd200;
    return t;
  endfunction

  function automatic in_t random_tick();
    in_t t;
    int  mag, err;
    case ($urandom_range(9))
      0:          mag = 0;
      1:          mag = $urandom_range(32768);
      2, 3, 4, 5: mag = $urandom_range(1, 512);
      default:    mag = $urandom_range(1, 4096);
    endcase
    err = $urandom_range(1) ? mag : -mag;
    if (err > 32767) err = -32768;
    t.in_error_band = ($urandom_range(99) < 20);
    t.speed_error   = err[15:0];
    case ($urandom_range(9))
      0:       t.step_ms = 16'($urandom_range(65535));
      1:       t.step_ms = 16'd0;
      default: t.step_ms = 16'($urandom_range(1, 200));
    endcase
    case ($urandom_range(19))
      0:       t.measured_speed = 16'd0;
      1:       t.measured_speed = 16'hFFFF;
      2:       t.measured_speed = cfg_sh.speed_min;
      3:       t.measured_speed = cfg_sh.speed_max;
      4:       t.measured_speed = 16'($urandom_range(65535));
      default: t.measured_speed = 16'($urandom_range(cfg_sh.speed_min, cfg_sh.speed_max));
    endcase
    if ($urandom_range(4) == 0) t.error_magnitude = 16'($urandom_range(32768));
    else t.error_magnitude = 16'((err < 0) ? -err : err);
    t.time_now = $urandom;
    t.band_enter = 16'(($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(300));
    t.rate_up =
      16'(($urandom_range(7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 1024));
    t.rate_down =
      16'(($urandom_range(7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 1024));
    t.inertia_up = 16'(($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(256));
    t.inertia_down =
      16'(($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(256));
    t.response_delay_ms =
      16'(($urandom_range(7) == 0) ? $urandom_range(65535) : $urandom_range(500));
    return t;
  endfunction

  initial begin
    in_t t;
    int  p, i;
    cfg_sh = cfg_t'{31'd65536, 16'd256, 16'd5000, 12'd300, 6'd0, 6'd0, 16'd5120, 16'd256};

    cfg_plan[0] = cfg_t'{31'd65536, 16'd256, 16'd5000, 12'd300, 6'd5, 6'd9, 16'd5120, 16'd256};
    cfg_plan[1] = cfg_t'{31'd0, 16'd0, 16'd0, 12'd0, 6'd63, 6'd1, 16'hFFFF, 16'd0};
    cfg_plan[2] = cfg_t'{31'h7FFFFFFF, 16'hFFFF, 16'hFFFF, 12'd3000, 6'd1, 6'd63,
                         16'hFFFF, 16'd0};
    cfg_plan[3] = cfg_t'{31'd1000000, 16'd700, 16'd2000, 12'd1000, 6'd0, 6'd12,
                         16'd3000, 16'd1000};
    // Both limits are always met in this setting, so every tick holds or leaks.
    cfg_plan[4] = cfg_t'{31'd200000, 16'd100, 16'd800, 12'd150, 6'd33, 6'd0,
                         16'd0, 16'hFFFF};
    cfg_plan[5] = cfg_t'{31'd16777216, 16'd400, 16'd10000, 12'd500, 6'd7, 6'd8,
                         16'd6000, 16'd100};
    cfg_plan[6] = cfg_plan[0];
    pace_plan[0] = PACE_STEADY;
    pace_plan[1] = PACE_SEND_GAPS;
    pace_plan[2] = PACE_RECV_STALLS;
    pace_plan[3] = PACE_BOTH;
    pace_plan[4] = PACE_STEADY;
    pace_plan[5] = PACE_SEND_GAPS;
    pace_plan[6] = PACE_RECV_STALLS;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    set_pace(PACE_STEADY);

    // Reset configuration: no press line is set, so planning stops early.
    tick_q.push_back(base_tick(1, 0, 0, 1000, 0));
    tick_q.push_back(base_tick(0, 32767, 65535, 1000, 32767));
    tick_q.push_back(base_tick(1, 0, 0, 1000, 0));
    tick_q.push_back(base_tick(0, -1, 1, 1000, 1));
    tick_q.push_back(base_tick(0, 100, 50, 5120, 100));
    tick_q.push_back(base_tick(0, -100, 50, 256, 100));
    tick_q.push_back(base_tick(0, 0, 100, 1000, 0));
    wait_drained();

    program_regs(cfg_plan[0]);
    // Two small positive ticks leave a tiny integral that the leak then snaps to zero.
    tick_q.push_back(base_tick(0, 10, 100, 1000, 10));
    tick_q.push_back(base_tick(0, 10, 100, 1000, 10));
    tick_q.push_back(base_tick(1, 0, 0, 1000, 0));
    tick_q.push_back(base_tick(0, -32768, 65535, 1000, 32768));
    tick_q.push_back(base_tick(0, 0, 0, 2000, 0));
    t = base_tick(0, 50, 10, 2000, 50);
    t.rate_up = 16'd0;
    tick_q.push_back(t);
    t = base_tick(0, -600, 10, 2000, 600);
    t.rate_down = 16'd0;
    tick_q.push_back(t);
    t = base_tick(0, 600, 10, 2000, 600);
    t.inertia_up = 16'hFFFF;
    tick_q.push_back(t);
    t.response_delay_ms = 16'd0;
    tick_q.push_back(t);
    t = base_tick(0, 511, 10, 2000, 511);
    t.band_enter = 16'hFFFF;
    tick_q.push_back(t);
    t = base_tick(0, 512, 10, 2000, 512);
    t.band_enter = 16'hFFFF;
    tick_q.push_back(t);
    t = base_tick(0, 20, 10, 2000, 20);
    t.rate_up = 16'hFFFF;
    t.response_delay_ms = 16'd0;
    tick_q.push_back(t);
    t = base_tick(0, 32767, 65535, 1000, 32768);
    t.time_now = 32'hFFFF_FFFF;
    t.band_enter = 16'hFFFF;
    t.rate_up = 16'hFFFF;
    t.rate_down = 16'hFFFF;
    t.inertia_up = 16'hFFFF;
    t.inertia_down = 16'hFFFF;
    t.response_delay_ms = 16'hFFFF;
    tick_q.push_back(t);
    tick_q.push_back(base_tick(0, 300, 10, 65535, 300));
    tick_q.push_back(base_tick(0, -300, 10, 0, 300));
    tick_q.push_back(base_tick(1, 0, 0, 1000, 0));
    tick_q.push_back(base_tick(0, 300, 10, 2000, 0));
    wait_drained();

    for (p = 0; p < PHASES; p++) begin
      program_regs(cfg_plan[p]);
      set_pace(pace_plan[p]);
      for (i = 0; i < ITEMS_PER_PHASE; i++) begin
        // Halfway through one phase the sender holds off until the DUT runs dry.
        if (p == 3 && i == ITEMS_PER_PHASE / 2) wait_drained();
        tick_q.push_back(random_tick());
      end
      wait_drained();
    end

    if (plan_q.size() != 0) report_mismatch("planned results left over");
    if (n_err == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
